// ===== src/brr_pkg.sv =====
// Shared types and constants for the BRR chunk decoder.
// No dependencies; the decoder top and brr_sample_calc use it.
package brr_pkg;

  localparam int unsigned SamplesPerChunk = 16;
  localparam int unsigned NibbleIdxW      = $clog2(SamplesPerChunk);
  localparam int unsigned DataW           = 64;
  localparam int unsigned HistW           = 15;
  localparam int unsigned SampleW         = 16;
  localparam int unsigned CalcW           = 21;

  localparam logic [3:0] MaxValidRange = 4'hc;
  localparam logic signed [SampleW-1:0] MaxPcm = 16'sh7fff;
  localparam logic signed [SampleW-1:0] MinPcm = -16'sh8000;
  localparam logic signed [HistW-1:0] OverRangeNeg = -15'sd2048;

  typedef enum logic [1:0] {
    FILT_NONE  = 2'd0,
    FILT_ONE   = 2'd1,
    FILT_TWO   = 2'd2,
    FILT_THREE = 2'd3
  } filter_e;

  // Per-chunk decode controls taken from the header.
  typedef struct packed {
    logic [3:0] range;
    filter_e    filter;
  } dec_ctl_t;

endpackage

// ===== src/brr_if.sv =====
// Valid/ready channel interfaces for chunk input beats and sample output beats.
// Depends on nothing beyond plain logic types.
interface brr_chunk_if;
  logic        valid;
  logic        ready;
  logic [7:0]  header;
  logic [31:0] data_first;
  logic [31:0] data_second;
  logic        new_sample;
  logic        final_chunk;

  modport source (output valid, header, data_first, data_second, new_sample, final_chunk,
                  input ready);
  modport sink   (input valid, header, data_first, data_second, new_sample, final_chunk,
                  output ready);
endinterface

interface brr_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_of_chunk;
  logic               end_of_sample;
  logic               loop_flag;

  modport source (output valid, sample, last_of_chunk, end_of_sample, loop_flag,
                  input ready);
  modport sink   (input valid, sample, last_of_chunk, end_of_sample, loop_flag,
                  output ready);
endinterface

// ===== src/brr_adpcm_chunk_decoder.sv =====
// Top level of the BRR ADPCM chunk decoder.
// Depends on brr_pkg, brr_if.sv (channel interfaces) and brr_sample_calc.
//
// Each accepted chunk beat (header plus eight data bytes) is held in a chunk
// register and decoded one sample per cycle while the output slot is free,
// high nibble of each byte first, through a single sample unit that feeds
// back the two 15-bit history values. A stalled sample beat holds the chunk
// in place until the output side takes it. The next chunk
// is accepted in the same cycle as the previous chunk's sixteenth sample
// moves into the output register, so chunks stream without gaps. The output
// register decouples the two sides: a finished sample can wait while decoding
// of the next chunk is queued up. new_sample clears the history and the ended
// flag as the chunk is taken. Once a chunk with the end bit, or one marked
// final_chunk, has been decoded, following chunks are taken at once and
// dropped without samples until one arrives with new_sample set. The last
// sample of each chunk carries last_of_chunk, plus end_of_sample and
// loop_flag where they apply. There is no configuration and no reset sweep.
module brr_adpcm_chunk_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  brr_chunk_if.sink           chunk_i,
  brr_sample_if.source        sample_o
);

  localparam logic [brr_pkg::NibbleIdxW-1:0] LastIdx =
    brr_pkg::NibbleIdxW'(brr_pkg::SamplesPerChunk - 1);

  // Chunk register and decode position
  logic                                 busy_q, busy_d;
  logic [brr_pkg::NibbleIdxW-1:0]       idx_q, idx_d;
  logic [brr_pkg::DataW-1:0]            data_q;
  brr_pkg::dec_ctl_t                    ctl_q;
  logic                                 stop_q;
  logic                                 end_loop_q;

  // Decoder state
  logic signed [brr_pkg::HistW-1:0]     hist_one_q, hist_one_d;
  logic signed [brr_pkg::HistW-1:0]     hist_two_q, hist_two_d;
  logic                                 ended_q, ended_d;

  // Output register
  logic                                 out_valid_q, out_valid_d;
  logic signed [brr_pkg::SampleW-1:0]   out_sample_q;
  logic                                 out_last_q;
  logic                                 out_eos_q;
  logic                                 out_loop_q;

  logic                                 out_free;
  logic                                 step;
  logic                                 step_last;
  logic                                 accept;
  logic                                 ended_now;
  logic                                 take_chunk;
  logic [brr_pkg::NibbleIdxW-1:0]       nib_sel;
  logic [3:0]                           nibble;
  logic signed [brr_pkg::HistW-1:0]     new_value;

  // Advance one sample whenever a chunk is held and the output slot is free.
  assign out_free  = !out_valid_q || sample_o.ready;
  assign step      = busy_q && out_free;
  assign step_last = step && (idx_q == LastIdx);

  assign chunk_i.ready = !busy_q || step_last;
  assign accept        = chunk_i.valid && chunk_i.ready;

  // Ended flag as it stands once the chunk now finishing is counted.
  assign ended_now  = ended_q || (step_last && stop_q);
  assign take_chunk = accept && (chunk_i.new_sample || !ended_now);

  // Nibble zero sits in the top four bits of the data word.
  assign nib_sel = LastIdx - idx_q;
  assign nibble  = data_q[{nib_sel, 2'b00} +: 4];

  brr_sample_calc u_calc (
    .nibble_i   (nibble),
    .ctl_i      (ctl_q),
    .hist_one_i (hist_one_q),
    .hist_two_i (hist_two_q),
    .value_o    (new_value)
  );

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    hist_one_d  = hist_one_q;
    hist_two_d  = hist_two_q;
    ended_d     = ended_now;
    out_valid_d = out_valid_q;

    if (sample_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + 1'b1;
      hist_two_d  = hist_one_q;
      hist_one_d  = new_value;
      if (step_last) begin
        busy_d = 1'b0;
      end
    end
    // A fresh sample drops the history, after the finishing chunk wrote it.
    if (accept && chunk_i.new_sample) begin
      hist_one_d = '0;
      hist_two_d = '0;
      ended_d    = 1'b0;
    end
    if (take_chunk) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      hist_one_q  <= '0;
      hist_two_q  <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      hist_one_q  <= hist_one_d;
      hist_two_q  <= hist_two_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load a chunk on take, a sample on step.
  always_ff @(posedge clk_i) begin
    if (take_chunk) begin
      data_q       <= {chunk_i.data_first, chunk_i.data_second};
      ctl_q.range  <= chunk_i.header[7:4];
      ctl_q.filter <= brr_pkg::filter_e'(chunk_i.header[3:2]);
      stop_q       <= chunk_i.header[0] || chunk_i.final_chunk;
      end_loop_q   <= chunk_i.header[0] && chunk_i.header[1];
    end
    if (step) begin
      out_sample_q <= {new_value, 1'b0};
      out_last_q   <= (idx_q == LastIdx);
      out_eos_q    <= (idx_q == LastIdx) && stop_q;
      out_loop_q   <= (idx_q == LastIdx) && end_loop_q;
    end
  end

  assign sample_o.valid         = out_valid_q;
  assign sample_o.sample        = out_sample_q;
  assign sample_o.last_of_chunk = out_last_q;
  assign sample_o.end_of_sample = out_eos_q;
  assign sample_o.loop_flag     = out_loop_q;

`ifndef SYNTHESIS
  // No chunk is held while the sample stands ended.
  a_ended_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> !busy_q)
    else $error("chunk held after sample ended");

  // Input stays closed while a chunk still has samples to go.
  a_no_early_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !step_last) |-> !chunk_i.ready)
    else $error("chunk input opened mid-chunk");

  // The sixteenth step presents a last-of-chunk beat next cycle.
  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_last |=> (sample_o.valid && sample_o.last_of_chunk))
    else $error("last sample of chunk not marked");

  // End and loop markers only ride on a chunk's last sample.
  a_markers_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_o.valid && (sample_o.end_of_sample || sample_o.loop_flag))
      |-> sample_o.last_of_chunk)
    else $error("end or loop marker off the last sample");
`endif

endmodule

// ===== src/brr_sample_calc.sv =====
// One BRR sample: range-scale a nibble, add the filter prediction, clamp and wrap.
// Depends on brr_pkg.
module brr_sample_calc (
  input  logic [3:0]                             nibble_i,
  input  brr_pkg::dec_ctl_t                      ctl_i,
  input  logic signed [brr_pkg::HistW-1:0]       hist_one_i,
  input  logic signed [brr_pkg::HistW-1:0]       hist_two_i,
  output logic signed [brr_pkg::HistW-1:0]       value_o
);

  logic signed [brr_pkg::CalcW-1:0]   nib_x;
  logic signed [brr_pkg::CalcW-1:0]   scaled;
  logic signed [brr_pkg::CalcW-1:0]   p1;
  logic signed [brr_pkg::CalcW-1:0]   p2;
  logic signed [brr_pkg::CalcW-1:0]   p1_x3;
  logic signed [brr_pkg::CalcW-1:0]   p1_x13;
  logic signed [brr_pkg::CalcW-1:0]   p2_x3;
  logic signed [brr_pkg::CalcW-1:0]   pred;
  logic signed [brr_pkg::CalcW-1:0]   total;
  logic signed [brr_pkg::SampleW-1:0] clamped;

  assign nib_x  = {{(brr_pkg::CalcW-4){nibble_i[3]}}, nibble_i};
  assign p1     = {{(brr_pkg::CalcW-brr_pkg::HistW){hist_one_i[brr_pkg::HistW-1]}}, hist_one_i};
  assign p2     = {{(brr_pkg::CalcW-brr_pkg::HistW){hist_two_i[brr_pkg::HistW-1]}}, hist_two_i};
  assign p1_x3  = p1 + (p1 <<< 1);
  assign p1_x13 = (p1 <<< 3) + (p1 <<< 2) + p1;
  assign p2_x3  = p2 + (p2 <<< 1);

  // Ranges above twelve collapse to zero or -2048 by sign.
  always_comb begin
    if (ctl_i.range <= brr_pkg::MaxValidRange) begin
      scaled = (nib_x <<< ctl_i.range) >>> 1;
    end else if (nibble_i[3]) begin
      scaled = {{(brr_pkg::CalcW-brr_pkg::HistW){1'b1}}, brr_pkg::OverRangeNeg};
    end else begin
      scaled = '0;
    end
  end

  always_comb begin
    unique case (ctl_i.filter)
      brr_pkg::FILT_ONE:   pred = p1 + ((-p1) >>> 4);
      brr_pkg::FILT_TWO:   pred = (p1 <<< 1) + ((-p1_x3) >>> 5) - p2 + (p2 >>> 4);
      brr_pkg::FILT_THREE: pred = (p1 <<< 1) + ((-p1_x13) >>> 6) - p2 + (p2_x3 >>> 4);
      default:             pred = '0;
    endcase
  end

  assign total = scaled + pred;

  // Clamp to 16 bits, then keep the low 15 as the new history value.
  always_comb begin
    if (total > brr_pkg::CalcW'(brr_pkg::MaxPcm)) begin
      clamped = brr_pkg::MaxPcm;
    end else if (total < brr_pkg::CalcW'(brr_pkg::MinPcm)) begin
      clamped = brr_pkg::MinPcm;
    end else begin
      clamped = total[brr_pkg::SampleW-1:0];
    end
  end

  assign value_o = clamped[brr_pkg::HistW-1:0];

endmodule
